// ===== sv/running_median_two_heaps_core_defines.svh =====
// assertion macros for the running median core
`ifndef RUNNING_MEDIAN_TWO_HEAPS_CORE_DEFINES_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define RMH_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMH_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rmh_pkg.sv =====
package rmh_pkg;
  // heap selector
  localparam logic HEAP_LOWER = 1'b0;
  localparam logic HEAP_UPPER = 1'b1;
  // request commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;
endpackage

// ===== sv/rmh_heap_mem.sv =====
module rmh_heap_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int DW    = 31
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/running_median_two_heaps_core.sv =====
// channel  | ports                                  | direction
// request  | in_valid in_ready in_cmd in_value      | in
// result   | out_valid out_ready out_median         | out
//          | out_count out_rejected                 |
// one request at a time; a clear or rejected insert goes straight to the result
// pop: read last entry, take it as the top, then per level of sift-down (read left, read right, write)
// each sift-up: start, then per level (read parent, write); median read from the larger heap's top
// worst insert pops one heap and sifts two values up, over ten heap levels
// no clearing pass: sizes reset to zero, entries are written before read
// a waiting result holds the block; the next request is taken once it leaves
module running_median_two_heaps_core #(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_cmd,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_median,
  output logic [10:0]            out_count,
  output logic                   out_rejected
);
  import rmh_pkg::*;

  localparam int DEPTH = (CAPACITY + 1) / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = $clog2(DEPTH + 1);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int PW    = SW + 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_POPRD = 4'd1, S_POPLAST = 4'd2,
    S_SDRD = 4'd3, S_SDL = 4'd4, S_SDR = 4'd5, S_UPSTART = 4'd6,
    S_UPRD = 4'd7, S_UPCMP = 4'd8, S_MED = 4'd9, S_MEDW = 4'd10, S_OUT = 4'd11;

  logic [3:0] st_r;
  logic [SW-1:0] lsz_r, usz_r;
  logic [VALUE_WIDTH-1:0] med_r, val_r, cur_r, moved_r, lval_r;
  logic heap_r, ins_heap_r, second_r, rej_r;
  logic [PW-1:0] pos_r, best_r;

  logic we [2];
  logic [AW-1:0] waddr, raddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [VALUE_WIDTH-1:0] rd [2];
  logic [VALUE_WIDTH-1:0] rdh;

  // two heap memories
  for (genvar g = 0; g < 2; g++) begin : g_mem
    rmh_heap_mem #(.DEPTH(DEPTH), .AW(AW), .DW(VALUE_WIDTH)) u_mem (
      .clk(clk), .we(we[g]), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rd[g]));
  end
  assign rdh = heap_r ? rd[1] : rd[0];

  // compare in the order of the active heap: lower is max-heap
  function automatic logic outr(input logic h, input logic [VALUE_WIDTH-1:0] a,
                                input logic [VALUE_WIDTH-1:0] b);
    outr = h ? (a < b) : (a > b);
  endfunction

  logic [SW-1:0] hsz;
  logic [PW-1:0] left, right, parent;
  logic [CW-1:0] held;
  logic sd_rwin;
  assign hsz = heap_r ? usz_r : lsz_r;
  assign left = {pos_r[PW-2:0], 1'b1};
  assign right = left + PW'(1);
  assign parent = (pos_r - PW'(1)) >> 1;
  assign held = CW'(lsz_r) + CW'(usz_r);

  // right child wins over both the sifted value and the left child
  assign sd_rwin = (right < PW'(hsz)) &&
                   outr(heap_r, rdh, (best_r == pos_r) ? cur_r : lval_r) &&
                   outr(heap_r, rdh, lval_r);

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_median = med_r;
  assign out_count = 11'(held);
  assign out_rejected = rej_r;

  // memory port control
  always_comb begin
    we[0] = 1'b0; we[1] = 1'b0;
    waddr = AW'(pos_r); wdata = cur_r; raddr = AW'(pos_r);
    unique case (st_r)
      S_POPRD: raddr = AW'(hsz - SW'(1));
      S_SDRD:  raddr = AW'(left);
      S_SDL:   raddr = AW'(right);
      S_UPRD:  raddr = AW'(parent);
      S_MED:   raddr = '0;
      S_SDR, S_UPCMP, S_POPLAST, S_UPSTART: ;
      default: ;
    endcase
    if (st_r == S_SDR) begin
      // write back the sift-down step: winning child moves up, else the sifted value settles
      we[heap_r] = 1'b1; waddr = AW'(pos_r);
      wdata = sd_rwin ? rdh : ((best_r != pos_r) ? lval_r : cur_r);
    end else if (st_r == S_UPCMP) begin
      we[heap_r] = 1'b1; waddr = AW'(pos_r);
      wdata = (pos_r != '0 && outr(heap_r, cur_r, rdh)) ? rdh : cur_r;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; lsz_r <= '0; usz_r <= '0; med_r <= '0; rej_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (in_valid) begin
          val_r <= in_value; rej_r <= 1'b0; second_r <= 1'b0;
          if (in_cmd == CMD_CLEAR) begin
            lsz_r <= '0; usz_r <= '0; med_r <= '0; st_r <= S_OUT;
          end else if (held >= CW'(CAPACITY)) begin
            rej_r <= 1'b1; st_r <= S_OUT;
          end else if (held == '0) begin
            ins_heap_r <= HEAP_LOWER; heap_r <= HEAP_LOWER; st_r <= S_UPSTART;
          end else if (in_value > med_r) begin
            ins_heap_r <= HEAP_UPPER;
            if (usz_r > lsz_r) begin
              heap_r <= HEAP_UPPER; st_r <= S_POPRD;
            end else begin
              heap_r <= HEAP_UPPER; st_r <= S_UPSTART;
            end
          end else begin
            ins_heap_r <= HEAP_LOWER;
            if (lsz_r > usz_r) begin
              heap_r <= HEAP_LOWER; st_r <= S_POPRD;
            end else begin
              heap_r <= HEAP_LOWER; st_r <= S_UPSTART;
            end
          end
        end
        S_POPRD: begin
          // read last entry first; pos is zero from here
          pos_r <= '0; st_r <= S_POPLAST;
        end
        S_POPLAST: begin
          if (heap_r) usz_r <= usz_r - SW'(1); else lsz_r <= lsz_r - SW'(1);
          pos_r <= '0; st_r <= S_SDRD;
          // last entry replaces the top; the top itself arrives next cycle
          cur_r <= rdh;
        end
        S_SDRD: begin
          if (pos_r == '0) moved_r <= rdh;
          st_r <= S_SDL;
        end
        S_SDL: begin
          lval_r <= rdh; st_r <= S_SDR;
          if (left < PW'(hsz) && outr(heap_r, rdh, cur_r)) best_r <= left;
          else best_r <= pos_r;
        end
        S_SDR: begin
          if (sd_rwin) begin
            pos_r <= right; st_r <= S_SDRD;
          end else if (best_r != pos_r) begin
            pos_r <= best_r; st_r <= S_SDRD;
          end else begin
            heap_r <= ~heap_r; cur_r <= moved_r; second_r <= 1'b1;
            st_r <= S_UPSTART;
          end
        end
        S_UPSTART: begin
          if (!second_r) cur_r <= val_r;
          if (heap_r) begin
            pos_r <= PW'(usz_r); usz_r <= usz_r + SW'(1);
          end else begin
            pos_r <= PW'(lsz_r); lsz_r <= lsz_r + SW'(1);
          end
          st_r <= S_UPRD;
        end
        S_UPRD: st_r <= S_UPCMP;
        S_UPCMP: begin
          if (pos_r != '0 && outr(heap_r, cur_r, rdh)) begin
            pos_r <= parent; st_r <= S_UPRD;
          end else if (heap_r != ins_heap_r) begin
            heap_r <= ins_heap_r; cur_r <= val_r; second_r <= 1'b0;
            st_r <= S_UPSTART;
          end else st_r <= S_MED;
        end
        S_MED: begin
          heap_r <= (usz_r > lsz_r) ? HEAP_UPPER : HEAP_LOWER; st_r <= S_MEDW;
        end
        S_MEDW: begin
          med_r <= (usz_r > lsz_r) ? rd[1] : rd[0]; st_r <= S_OUT;
        end
        S_OUT: if (out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/rmh_checker.sv =====
`include "running_median_two_heaps_core_defines.svh"
module rmh_checker (
  input logic clk, input logic rst_n,
  input logic in_valid, input logic in_ready,
  input logic out_valid, input logic out_ready,
  input logic [10:0] out_count, input logic out_rejected
);
  `RMH_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready, "ready while result waits")
  `RMH_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  `RMH_ASSERT_IMP(a_rej, clk, rst_n, out_valid && out_rejected, out_count != 11'd0,
    "reject on empty store")
endmodule

bind running_median_two_heaps_core rmh_checker u_rmh_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_count(out_count),
  .out_rejected(out_rejected));

// ===== tb/sv/running_median_two_heaps_core_tb.sv =====
module running_median_two_heaps_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmh_pkg::*;

  localparam int CAPACITY = 1024;
  localparam int VW = 31;
  localparam int HALF = (CAPACITY + 1) / 2;

  typedef struct packed {
    logic          cmd;
    logic [VW-1:0] value;
  } sample_req_t;

  typedef struct packed {
    logic [VW-1:0] median;
    logic [10:0]   count;
    logic          rejected;
  } median_res_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          in_cmd = CMD_INSERT;
  logic [VW-1:0] in_value = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [VW-1:0] out_median;
  logic [10:0]   out_count;
  logic          out_rejected;

  running_median_two_heaps_core #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VW)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_median(out_median),
    .out_count(out_count), .out_rejected(out_rejected)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [VW-1:0] lo_heap [HALF];
  logic [VW-1:0] hi_heap [HALF];
  int unsigned   lo_size, hi_size;
  logic [VW-1:0] med_now;

  sample_req_t  pending_reqs[$];
  median_res_t  expected_medians[$];
  int           idle_pct = 0, stall_pct = 0;
  int           hold_off = 0;
  int           n_errors = 0, n_results = 0, n_rejects = 0, n_clears = 0;

  function automatic bit above(logic [VW-1:0] a, logic [VW-1:0] b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  task automatic push_heap(bit is_max, logic [VW-1:0] v);
    int unsigned p, par;
    logic [VW-1:0] t;
    if (is_max) begin
      p = lo_size; lo_heap[p] = v; lo_size++;
      while (p > 0) begin
        par = (p - 1) / 2;
        if (!above(lo_heap[p], lo_heap[par], 1)) break;
        t = lo_heap[p]; lo_heap[p] = lo_heap[par]; lo_heap[par] = t; p = par;
      end
    end else begin
      p = hi_size; hi_heap[p] = v; hi_size++;
      while (p > 0) begin
        par = (p - 1) / 2;
        if (!above(hi_heap[p], hi_heap[par], 0)) break;
        t = hi_heap[p]; hi_heap[p] = hi_heap[par]; hi_heap[par] = t; p = par;
      end
    end
  endtask

  // pop from one heap, sift-down over in-range children, left wins ties
  task automatic pop_heap(bit is_max, output logic [VW-1:0] top);
    logic [VW-1:0] h [HALF];
    int unsigned sz, p, l, r, b;
    logic [VW-1:0] t;
    if (is_max) begin h = lo_heap; sz = lo_size; end
    else begin h = hi_heap; sz = hi_size; end
    top = h[0];
    sz--;
    h[0] = h[sz];
    p = 0;
    forever begin
      l = 2 * p + 1; r = l + 1; b = p;
      if (l < sz && above(h[l], h[b], is_max)) b = l;
      if (r < sz && above(h[r], h[b], is_max) && above(h[r], h[l], is_max)) b = r;
      if (b == p) break;
      t = h[p]; h[p] = h[b]; h[b] = t; p = b;
    end
    if (is_max) begin lo_heap = h; lo_size = sz; end
    else begin hi_heap = h; hi_size = sz; end
  endtask

  task automatic predict_median(sample_req_t rq);
    median_res_t e;
    logic [VW-1:0] m;
    e.rejected = 1'b0;
    if (rq.cmd == CMD_CLEAR) begin
      lo_size = 0; hi_size = 0; med_now = '0;
    end else if (lo_size + hi_size >= CAPACITY) begin
      e.rejected = 1'b1;
    end else begin
      if (lo_size + hi_size == 0) push_heap(1, rq.value);
      else if (rq.value > med_now) begin
        if (hi_size > lo_size) begin pop_heap(0, m); push_heap(1, m); end
        push_heap(0, rq.value);
      end else begin
        if (lo_size > hi_size) begin pop_heap(1, m); push_heap(0, m); end
        push_heap(1, rq.value);
      end
      if (hi_size > lo_size) med_now = hi_heap[0];
      else if (lo_size > 0) med_now = lo_heap[0];
      else med_now = '0;
    end
    e.median = med_now;
    e.count = 11'(lo_size + hi_size);
    expected_medians.push_back(e);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_median('{cmd: in_cmd, value: in_value});
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_cmd   <= pending_reqs[0].cmd;
          in_value <= pending_reqs[0].value;
          void'(pending_reqs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    median_res_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_medians.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result median=%0d count=%0d",
                                       out_median, out_count);
        end else begin
          e = expected_medians.pop_front();
          if (out_rejected) n_rejects++;
          if (out_median !== e.median || out_count !== e.count ||
              out_rejected !== e.rejected) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: exp med=%0d cnt=%0d rej=%0d got med=%0d cnt=%0d rej=%0d",
                       e.median, e.count, e.rejected, out_median, out_count, out_rejected);
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic add_req(logic cmd, logic [VW-1:0] v);
    pending_reqs.push_back('{cmd: cmd, value: v});
    if (cmd == CMD_CLEAR) n_clears++;
  endtask

  // wait until every request has been answered, sampling after the edge settles
  task automatic drain;
    while (pending_reqs.size() > 0 || in_valid || expected_medians.size() > 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  function automatic logic [VW-1:0] rand_val(int mode);
    case (mode)
      0: return VW'($urandom_range(15));
      1: return VW'($urandom);
      default: return VW'({VW{1'b1}} - $urandom_range(15));
    endcase
  endfunction

  // stimulus
  initial begin
    int phase, len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty clear, extremes, duplicates, alternating bit patterns, clear, small set, clear
    add_req(CMD_CLEAR, '0);
    add_req(CMD_INSERT, {VW{1'b1}});
    add_req(CMD_INSERT, '0);
    add_req(CMD_INSERT, {VW{1'b1}});
    add_req(CMD_INSERT, '0);
    for (int i = 0; i < 6; i++) add_req(CMD_INSERT, VW'(5));
    add_req(CMD_INSERT, VW'(31'h5555_5555));
    add_req(CMD_INSERT, VW'(31'h2AAA_AAAA));
    add_req(CMD_CLEAR, {VW{1'b1}});
    add_req(CMD_INSERT, VW'(7));
    add_req(CMD_INSERT, VW'(3));
    add_req(CMD_INSERT, VW'(9));
    add_req(CMD_CLEAR, '0);
    drain();

    // fill to capacity and overflow, with long receiver hold-off
    hold_off = 300;
    for (int i = 0; i < CAPACITY + 4; i++) add_req(CMD_INSERT, rand_val($urandom_range(2)));
    drain();
    add_req(CMD_CLEAR, '0);

    // random phases with varied idle and stall
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      len = 0;
      while (len < 80) begin
        if ($urandom_range(99) < 4) add_req(CMD_CLEAR, VW'($urandom));
        else add_req(CMD_INSERT, rand_val($urandom_range(2)));
        len++;
      end
      drain();
    end
    idle_pct = 0; stall_pct = 0;
    repeat (50) @(posedge clk);
    $display("covered %0d results, %0d full-store rejects, %0d clears",
             n_results, n_rejects, n_clears);
    if (n_errors == 0 && expected_medians.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/rmh_pkg.sv
sv/rmh_heap_mem.sv
sv/running_median_two_heaps_core.sv
sv/rmh_checker.sv
tb/sv/running_median_two_heaps_core_tb.sv
